>>> hw/rtl/ffsa_pkg.sv
package ffsa_pkg;

    localparam int SLOT_W       = 7;
    localparam int UNPLACED_W   = 16;
    localparam int SLOT_COUNT_W = 8;

    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 8'd128;
    localparam logic [UNPLACED_W-1:0]   UNPLACED_MAX     = 16'hFFFF;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PLACE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                  placed;
        logic [SLOT_W-1:0]     slot;
        logic [UNPLACED_W-1:0] unplaced;
    } result_t;

endpackage

>>> hw/rtl/ffsa_slot_mem.sv
module ffsa_slot_mem #(
    parameter int NUM_SLOTS   = 128,
    parameter int AMOUNT_BITS = 10
) (
    input  logic                                                aclk,
    input  logic                                                wr_en,
    input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
    input  logic [AMOUNT_BITS:0]                                wr_data,
    input  logic                                                rd_en,
    input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
    output logic [AMOUNT_BITS:0]                                rd_data
);

    // entry: {taken, capacity}
    logic [AMOUNT_BITS:0] mem [NUM_SLOTS];
    logic [AMOUNT_BITS:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ffsa_ctrl.sv
module ffsa_ctrl #(
    parameter int NUM_SLOTS   = 128,
    parameter int AMOUNT_BITS = 10
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic [ffsa_pkg::SLOT_COUNT_W-1:0]                   slot_count,
    input  logic                                                s_valid,
    output logic                                                s_ready,
    input  logic                                                s_command,
    input  logic [ffsa_pkg::SLOT_W-1:0]                         s_slot_index,
    input  logic [AMOUNT_BITS-1:0]                              s_amount,
    output logic                                                mem_wr_en,
    output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] mem_wr_addr,
    output logic [AMOUNT_BITS:0]                                mem_wr_data,
    output logic                                                mem_rd_en,
    output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] mem_rd_addr,
    input  logic [AMOUNT_BITS:0]                                mem_rd_data,
    output logic                                                res_valid,
    input  logic                                                res_ready,
    output ffsa_pkg::result_t                                   res
);

    localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W  = (CNT_W > ffsa_pkg::SLOT_COUNT_W) ? CNT_W : ffsa_pkg::SLOT_COUNT_W;
    localparam int SW     = (ADDR_W > ffsa_pkg::SLOT_W) ? ADDR_W : ffsa_pkg::SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    ffsa_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [AMOUNT_BITS-1:0]            amt_reg, amt_next;
    logic [CNT_W-1:0]                  limit_reg, limit_next;
    logic [CNT_W-1:0]                  issue_reg, issue_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]                 pend_addr_reg, pend_addr_next;
    logic                              placed_reg, placed_next;
    logic [ffsa_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [ffsa_pkg::UNPLACED_W-1:0]   unplaced_reg, unplaced_next;

    logic [CNT_W-1:0]                  limit_calc;
    logic                              load_in_range;
    logic [SW-1:0]                     idx_wide;
    logic [SW-1:0]                     pend_wide;
    logic [CNT_W-1:0]                  pend_plus1;
    logic [ffsa_pkg::UNPLACED_W-1:0]   unplaced_inc;
    logic                              hit;

    assign limit_calc = (IDX_W'(slot_count) > IDX_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
                                                                  : CNT_W'(slot_count);
    assign load_in_range = IDX_W'(s_slot_index) < IDX_W'(NUM_SLOTS);
    assign idx_wide      = SW'(s_slot_index);
    assign pend_wide     = SW'(pend_addr_reg);
    assign pend_plus1    = CNT_W'(pend_addr_reg) + CNT_W'(1);
    assign unplaced_inc  = (unplaced_reg == ffsa_pkg::UNPLACED_MAX) ? unplaced_reg
                                                                    : unplaced_reg + 1'b1;
    assign hit = pend_valid_reg && !mem_rd_data[AMOUNT_BITS]
                 && (amt_reg <= mem_rd_data[AMOUNT_BITS-1:0]);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        amt_next        = amt_reg;
        limit_next      = limit_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = issue_reg[ADDR_W-1:0];
        placed_next     = placed_reg;
        slot_next       = slot_reg;
        unplaced_next   = unplaced_reg;
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_wide[ADDR_W-1:0];
        mem_wr_data     = {1'b0, s_amount};
        mem_rd_en       = 1'b0;
        mem_rd_addr     = issue_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next = ffsa_pkg::cmd_t'(s_command);
                    amt_next = s_amount;
                    if (ffsa_pkg::cmd_t'(s_command) == ffsa_pkg::CMD_LOAD) begin
                        mem_wr_en     = load_in_range;
                        placed_next   = 1'b0;
                        slot_next     = s_slot_index;
                        unplaced_next = '0;
                        state_next    = S_DONE;
                    end else begin
                        limit_next  = limit_calc;
                        issue_next  = '0;
                        placed_next = 1'b0;
                        slot_next   = '0;
                        if (limit_calc == '0) begin
                            unplaced_next = unplaced_inc;
                            state_next    = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_addr_reg;
                    mem_wr_data = {1'b1, mem_rd_data[AMOUNT_BITS-1:0]};
                    placed_next = 1'b1;
                    slot_next   = pend_wide[ffsa_pkg::SLOT_W-1:0];
                    state_next  = S_DONE;
                end else if (pend_valid_reg && pend_plus1 == limit_reg) begin
                    unplaced_next = unplaced_inc;
                    state_next    = S_DONE;
                end else if (issue_reg != limit_reg) begin
                    mem_rd_en       = 1'b1;
                    pend_valid_next = 1'b1;
                    issue_next      = issue_reg + 1'b1;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            unplaced_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            unplaced_reg   <= unplaced_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        amt_reg       <= amt_next;
        limit_reg     <= limit_next;
        issue_reg     <= issue_next;
        pend_addr_reg <= pend_addr_next;
        placed_reg    <= placed_next;
        slot_reg      <= slot_next;
    end

    assign res.placed   = placed_reg;
    assign res.slot     = slot_reg;
    assign res.unplaced = unplaced_reg;

    a_rd_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_rd_en |-> (issue_reg < limit_reg))
        else $error("scan read beyond active slot count");

    a_scan_wr_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && mem_wr_en) |-> (pend_valid_reg && mem_wr_data[AMOUNT_BITS]))
        else $error("scan write without a checked fitting entry");

    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && cmd_reg == ffsa_pkg::CMD_LOAD)
        |-> (unplaced_reg == '0 && !placed_reg))
        else $error("load result must clear counter and report not placed");

endmodule

>>> hw/rtl/first_fit_slot_allocator_top.sv
// First-fit slot allocator.
// Input channel s_*: command 0 loads slot s_slot_index with capacity s_amount
// and frees it; command 1 places a request of size s_amount into the lowest
// free slot below the slot count whose capacity fits.
// Result channel m_*: one item per input item: placed flag, chosen slot
// (or the loaded index) and the saturating unplaced count.
// cfg_wr_en/cfg_wr_data set slot_count (reset 128, clamped to NUM_SLOTS);
// write it only while the block is idle.
// A load writes its table entry on accept and goes straight to the result.
// A place scans from slot 0 up and stops at the first free slot that fits,
// marking it taken, or after the last slot below the slot count (with no
// read at all for slot count zero). The scan reads one slot-table entry per
// cycle through a registered-read memory; a result register drives m_valid.
// Reset clears control state and the counter; the slot table needs no
// clearing since each slot's taken mark is written by its load.
// A stalled m_ready holds the result; one more item is accepted and worked
// on meanwhile, then waits until the result register frees.
module first_fit_slot_allocator_top #(
    parameter int NUM_SLOTS   = 128,
    parameter int AMOUNT_BITS = 10
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [ffsa_pkg::SLOT_COUNT_W-1:0]       cfg_wr_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_command,
    input  logic [ffsa_pkg::SLOT_W-1:0]             s_slot_index,
    input  logic [AMOUNT_BITS-1:0]                  s_amount,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_placed,
    output logic [ffsa_pkg::SLOT_W-1:0]             m_chosen_slot,
    output logic [ffsa_pkg::UNPLACED_W-1:0]         m_unplaced_total
);

    localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [ffsa_pkg::SLOT_COUNT_W-1:0] slot_count_reg;
    logic                              out_valid_reg;
    ffsa_pkg::result_t                 out_reg;

    logic                              mem_wr_en;
    logic [ADDR_W-1:0]                 mem_wr_addr;
    logic [AMOUNT_BITS:0]              mem_wr_data;
    logic                              mem_rd_en;
    logic [ADDR_W-1:0]                 mem_rd_addr;
    logic [AMOUNT_BITS:0]              mem_rd_data;
    logic                              res_valid;
    logic                              res_ready;
    ffsa_pkg::result_t                 res;

    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= ffsa_pkg::SLOT_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slot_count_reg <= cfg_wr_data;
            end
            if (res_ready) begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    ffsa_ctrl #(
        .NUM_SLOTS   (NUM_SLOTS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .slot_count   (slot_count_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_slot_index (s_slot_index),
        .s_amount     (s_amount),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    ffsa_slot_mem #(
        .NUM_SLOTS   (NUM_SLOTS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_slot_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_valid          = out_valid_reg;
    assign m_placed         = out_reg.placed;
    assign m_chosen_slot    = out_reg.slot;
    assign m_unplaced_total = out_reg.unplaced;

endmodule
